>>> hw/rtl/knn_pkg.sv
`timescale 1ns / 1ps
package knn_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int SQ_W    = 33;   // one squared coordinate difference
   localparam int D2_W    = 34;   // squared distance
   localparam int WGT_W   = 33;   // floor(2^32 / d2)

   // request function codes
   localparam logic [1:0] FUNC_LOAD_KEY  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_SLOT = 2'd1;
   localparam logic [1:0] FUNC_QUERY     = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_BLEND = 2'd0;
   localparam logic [1:0] STATUS_HIT   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_BAD   = 2'd3;

   // register indexes
   localparam logic CSR_NEIGHBOR_COUNT = 1'b0;
   localparam logic CSR_SAMPLES_IN_USE = 1'b1;

   localparam logic [3:0] K_RESET = 4'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

>>> hw/rtl/knn_ram.sv
`timescale 1ns / 1ps
module knn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/knn_div.sv
`timescale 1ns / 1ps
module knn_div #(
   parameter int N = 54,
   parameter int D = 37
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [N-1:0] quotient
);

   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  dvd_ff, dvd_in;
   logic [D-1:0]  dvs_ff, dvs_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [D:0]    shifted;
   logic [D:0]    diff;
   logic          ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, dvd_ff[N-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[D-1:0] : shifted[D-1:0];
         dvd_in = {dvd_ff[N-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> hw/rtl/knn_nearest.sv
`timescale 1ns / 1ps
module knn_nearest #(
   parameter int MAX_K = 8,
   parameter int IW    = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  insert,
   input  logic [IW-1:0]                         ins_idx,
   input  logic [knn_pkg::D2_W-1:0]              ins_d2,
   input  logic [$clog2(MAX_K + 1)-1:0]          k_eff,
   input  logic [(MAX_K > 1 ? $clog2(MAX_K) : 1)-1:0] rd_sel,
   output logic [IW-1:0]                         rd_idx,
   output logic [knn_pkg::D2_W-1:0]              rd_d2,
   output logic [$clog2(MAX_K + 1)-1:0]          used,
   output logic                                  head_zero
);

   localparam int KW = $clog2(MAX_K + 1);

   logic [IW-1:0]            idx_ff [MAX_K];
   logic [IW-1:0]            idx_in [MAX_K];
   logic [knn_pkg::D2_W-1:0] d2_ff  [MAX_K];
   logic [knn_pkg::D2_W-1:0] d2_in  [MAX_K];
   logic [KW-1:0]            used_ff, used_in;
   logic [MAX_K-1:0]         le;
   logic                     le_last;
   logic                     full;
   logic                     ins_ok;

   // sorted insertion: every cell compares against the new distance at once
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         le[j] = (KW'(j) < used_ff) && (d2_ff[j] <= ins_d2);
      end
      le_last = 1'b0;
      for (int j = 0; j < MAX_K; j++) begin
         if (KW'(j) == k_eff - KW'(1)) begin
            le_last = le[j];
         end
      end
      full    = used_ff >= k_eff;
      ins_ok  = insert && (!full || !le_last);
      used_in = used_ff;
      for (int j = 0; j < MAX_K; j++) begin
         idx_in[j] = idx_ff[j];
         d2_in[j]  = d2_ff[j];
      end
      if (clear) begin
         used_in = '0;
      end else if (ins_ok) begin
         if (!full) begin
            used_in = used_ff + KW'(1);
         end
         for (int j = 0; j < MAX_K; j++) begin
            if (!le[j]) begin
               if (j == 0) begin
                  idx_in[j] = ins_idx;
                  d2_in[j]  = ins_d2;
               end else if (le[j-1]) begin
                  idx_in[j] = ins_idx;
                  d2_in[j]  = ins_d2;
               end else begin
                  idx_in[j] = idx_ff[j-1];
                  d2_in[j]  = d2_ff[j-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      for (int j = 0; j < MAX_K; j++) begin
         idx_ff[j] <= idx_in[j];
         d2_ff[j]  <= d2_in[j];
      end
   end

   assign rd_idx    = idx_ff[rd_sel];
   assign rd_d2     = d2_ff[rd_sel];
   assign used      = used_ff;
   assign head_zero = d2_ff[0] == '0;

endmodule

>>> hw/rtl/knn_inverse_distance_interpolator.sv
`timescale 1ns / 1ps
// k-nearest-neighbour inverse-distance interpolator. Load transactions (no
// response) write a sample key or one slot position into on-chip RAM. A query
// scans the keys of samples 0..n-1 from the key RAM, one per cycle, keeping
// the k nearest in a sorted list, then computes one weight per kept neighbour
// and two quotients per slot on one shared bit-serial divider, which is N = 54
// bits wide at default parameters. Each response waits for the response
// register to be free; a new request is accepted as soon as the previous
// query has issued its last response. There is no clearing pass: sample RAM
// contents are undefined until loaded.
module knn_inverse_distance_interpolator #(
   parameter int MAX_SAMPLES = 64,
   parameter int MAX_K       = 8,
   parameter int SLOTS       = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [6:0]              csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [5:0]              req_sample_slot,
   input  logic [3:0]              req_player,
   input  logic signed [15:0]      req_coord_x,
   input  logic signed [15:0]      req_coord_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [15:0]      rsp_pos_x,
   output logic signed [15:0]      rsp_pos_y,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_slot_number,
   output logic                    rsp_last
);

   localparam int SAW    = MAX_SAMPLES > 1 ? $clog2(MAX_SAMPLES) : 1;
   localparam int SDEPTH = MAX_SAMPLES * SLOTS;
   localparam int SLAW   = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
   localparam int NW     = $clog2(MAX_SAMPLES + 1);
   localparam int KW     = $clog2(MAX_K + 1);
   localparam int KIW    = MAX_K > 1 ? $clog2(MAX_K) : 1;
   localparam int SW     = $clog2(SLOTS + 1);
   localparam int PROD_W = knn_pkg::COORD_W + knn_pkg::WGT_W + 1;
   localparam int ACC_W  = PROD_W + KW;
   localparam int WSUM_W = knn_pkg::WGT_W + KW;
   localparam int DIV_N  = ACC_W;
   localparam int DIV_D  = WSUM_W;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SCAN      = 5'd1;
   localparam logic [4:0] S_WGT_GO    = 5'd2;
   localparam logic [4:0] S_WGT_WT    = 5'd3;
   localparam logic [4:0] S_SLOT_ADDR = 5'd4;
   localparam logic [4:0] S_SLOT_DATA = 5'd5;
   localparam logic [4:0] S_SLOT_ACC  = 5'd6;
   localparam logic [4:0] S_DIVX_GO   = 5'd7;
   localparam logic [4:0] S_DIVX_WT   = 5'd8;
   localparam logic [4:0] S_DIVY_GO   = 5'd9;
   localparam logic [4:0] S_DIVY_WT   = 5'd10;
   localparam logic [4:0] S_EMIT      = 5'd11;
   localparam logic [4:0] S_HIT_ADDR  = 5'd12;
   localparam logic [4:0] S_HIT_DATA  = 5'd13;
   localparam logic [4:0] S_HIT_EMIT  = 5'd14;
   localparam logic [4:0] S_EMPTY     = 5'd15;
   localparam logic [4:0] S_BAD       = 5'd16;

   // control and configuration
   logic [4:0]          state_ff, state_in;
   logic [3:0]          k_ff, k_in;
   logic [6:0]          n_ff, n_in;
   logic [KW-1:0]       k_eff;
   logic [NW-1:0]       n_eff;

   // query context
   knn_pkg::coord_type  fx_ff, fx_in, fy_ff, fy_in;
   logic [SW-1:0]       slot_ff, slot_in, last_slot_ff, last_slot_in;
   logic [NW-1:0]       scan_ff, scan_in;
   logic                rd_v_ff, rd_v_in, sq_v_ff, sq_v_in;
   logic [SAW-1:0]      rd_idx_ff, rd_idx_in, sq_idx_ff, sq_idx_in;
   logic [knn_pkg::SQ_W-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [KIW-1:0]      nb_ff, nb_in;
   logic [knn_pkg::WGT_W-1:0] w_ff [MAX_K];
   logic [knn_pkg::WGT_W-1:0] w_in [MAX_K];
   logic [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic signed [PROD_W-1:0] prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [ACC_W-1:0]  accx_ff, accx_in, accy_ff, accy_in;
   knn_pkg::coord_type  qx_ff, qx_in, qy_ff, qy_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   knn_pkg::coord_type  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [SW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                rsp_last_ff, rsp_last_in;

   // memories and units
   logic                key_we, slot_we;
   logic [SAW-1:0]      key_waddr, key_raddr;
   logic [31:0]         key_rdata;
   logic [SLAW-1:0]     slot_waddr, slot_raddr;
   logic [31:0]         slot_rdata;
   logic                nr_clear, nr_ins;
   logic [SAW-1:0]      nr_idx;
   logic [knn_pkg::D2_W-1:0] nr_d2;
   logic [KW-1:0]       nr_used;
   logic                nr_head_zero;
   logic                div_start, div_busy, div_done;
   logic [DIV_N-1:0]    div_dividend, div_quot;
   logic [DIV_D-1:0]    div_divisor;

   // scratch
   logic                req_acc, out_free, sidx_ok, player_ok, nb_last;
   logic signed [16:0]  dx, dy;
   logic signed [33:0]  dx2, dy2;
   logic [knn_pkg::WGT_W-1:0] wq;
   logic signed [knn_pkg::WGT_W:0] w_sig;
   logic [ACC_W-1:0]    acc_mag;
   logic [15:0]         q_lo;

   knn_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata ({req_coord_x, req_coord_y}),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   knn_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata ({req_coord_x, req_coord_y}),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   knn_nearest #(.MAX_K(MAX_K), .IW(SAW)) u_nearest (
      .clock     (clock),
      .reset     (reset),
      .clear     (nr_clear),
      .insert    (nr_ins),
      .ins_idx   (sq_idx_ff),
      .ins_d2    (knn_pkg::D2_W'(sqx_ff) + knn_pkg::D2_W'(sqy_ff)),
      .k_eff     (k_eff),
      .rd_sel    (nb_ff),
      .rd_idx    (nr_idx),
      .rd_d2     (nr_d2),
      .used      (nr_used),
      .head_zero (nr_head_zero)
   );

   knn_div #(.N(DIV_N), .D(DIV_D)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // saturated register views
   always_comb begin
      if (k_ff == 4'd0) begin
         k_eff = KW'(1);
      end else if (32'(k_ff) > MAX_K) begin
         k_eff = KW'(MAX_K);
      end else begin
         k_eff = KW'(k_ff);
      end
      if (32'(n_ff) > MAX_SAMPLES) begin
         n_eff = NW'(MAX_SAMPLES);
      end else begin
         n_eff = NW'(n_ff);
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign req_acc   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sidx_ok   = 32'(req_sample_slot) < MAX_SAMPLES;
   assign player_ok = (req_player != 4'd0) && (32'(req_player) <= SLOTS);
   assign nb_last   = KW'(nb_ff) == nr_used - KW'(1);

   // distance datapath and per-neighbour arithmetic
   always_comb begin
      dx      = $signed({key_rdata[31], key_rdata[31:16]}) - $signed({fx_ff[15], fx_ff});
      dy      = $signed({key_rdata[15], key_rdata[15:0]}) - $signed({fy_ff[15], fy_ff});
      dx2     = dx * dx;
      dy2     = dy * dy;
      wq      = (div_quot[knn_pkg::WGT_W-1:0] == '0) ? knn_pkg::WGT_W'(1)
                                                      : div_quot[knn_pkg::WGT_W-1:0];
      w_sig   = $signed({1'b0, w_ff[nb_ff]});
      acc_mag = (state_ff == S_DIVX_GO) ? (accx_ff[ACC_W-1] ? ACC_W'(-accx_ff) : ACC_W'(accx_ff))
                                        : (accy_ff[ACC_W-1] ? ACC_W'(-accy_ff) : ACC_W'(accy_ff));
      q_lo    = div_quot[15:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      slot_in      = slot_ff;
      last_slot_in = last_slot_ff;
      scan_in      = scan_ff;
      rd_v_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      sq_v_in      = rd_v_ff;
      sq_idx_in    = rd_idx_ff;
      sqx_in       = dx2[knn_pkg::SQ_W-1:0];
      sqy_in       = dy2[knn_pkg::SQ_W-1:0];
      nb_in        = nb_ff;
      for (int j = 0; j < MAX_K; j++) begin
         w_in[j] = w_ff[j];
      end
      wsum_in      = wsum_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      key_we       = 1'b0;
      slot_we      = 1'b0;
      key_waddr    = SAW'(req_sample_slot);
      key_raddr    = SAW'(scan_ff);
      slot_waddr   = SLAW'(SLAW'(req_sample_slot) * SLAW'(SLOTS) + SLAW'(req_player) - SLAW'(1));
      slot_raddr   = SLAW'(SLAW'(nr_idx) * SLAW'(SLOTS) + SLAW'(slot_ff) - SLAW'(1));
      nr_clear     = 1'b0;
      nr_ins       = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_N'(64'h1_0000_0000);
      div_divisor  = DIV_D'(nr_d2);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            knn_pkg::CSR_NEIGHBOR_COUNT: k_in = csr_wdata[3:0];
            knn_pkg::CSR_SAMPLES_IN_USE: n_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_func)
                  knn_pkg::FUNC_LOAD_KEY: begin
                     key_we = sidx_ok;
                  end
                  knn_pkg::FUNC_LOAD_SLOT: begin
                     slot_we = sidx_ok && player_ok;
                  end
                  knn_pkg::FUNC_QUERY: begin
                     fx_in        = req_coord_x;
                     fy_in        = req_coord_y;
                     nr_clear     = 1'b1;
                     nb_in        = '0;
                     wsum_in      = '0;
                     accx_in      = '0;
                     accy_in      = '0;
                     scan_in      = '0;
                     slot_in      = (req_player == 4'd0) ? SW'(1) : SW'(req_player);
                     last_slot_in = (req_player == 4'd0) ? SW'(SLOTS) : SW'(req_player);
                     if (32'(req_player) > SLOTS) begin
                        state_in = S_BAD;
                     end else if (n_eff == '0) begin
                        state_in = S_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // read key, square differences, insert: three-stage pipeline
            if (scan_ff < n_eff) begin
               rd_v_in   = 1'b1;
               rd_idx_in = SAW'(scan_ff);
               scan_in   = scan_ff + NW'(1);
            end
            nr_ins = sq_v_ff;
            if (scan_ff == n_eff && !rd_v_ff && !sq_v_ff) begin
               state_in = nr_head_zero ? S_HIT_ADDR : S_WGT_GO;
            end
         end
         S_WGT_GO: begin
            div_start = 1'b1;
            state_in  = S_WGT_WT;
         end
         S_WGT_WT: begin
            if (div_done) begin
               w_in[nb_ff] = wq;
               wsum_in     = wsum_ff + WSUM_W'(wq);
               if (nb_last) begin
                  nb_in    = '0;
                  state_in = S_SLOT_ADDR;
               end else begin
                  nb_in    = nb_ff + KIW'(1);
                  state_in = S_WGT_GO;
               end
            end
         end
         S_SLOT_ADDR: begin
            state_in = S_SLOT_DATA;
         end
         S_SLOT_DATA: begin
            prodx_in = $signed(slot_rdata[31:16]) * w_sig;
            prody_in = $signed(slot_rdata[15:0]) * w_sig;
            state_in = S_SLOT_ACC;
         end
         S_SLOT_ACC: begin
            accx_in = accx_ff + ACC_W'(prodx_ff);
            accy_in = accy_ff + ACC_W'(prody_ff);
            if (nb_last) begin
               nb_in    = '0;
               state_in = S_DIVX_GO;
            end else begin
               nb_in    = nb_ff + KIW'(1);
               state_in = S_SLOT_ADDR;
            end
         end
         S_DIVX_GO: begin
            div_start    = 1'b1;
            div_dividend = acc_mag;
            div_divisor  = wsum_ff;
            state_in     = S_DIVX_WT;
         end
         S_DIVX_WT: begin
            if (div_done) begin
               qx_in    = accx_ff[ACC_W-1] ? -q_lo : q_lo;
               state_in = S_DIVY_GO;
            end
         end
         S_DIVY_GO: begin
            div_start    = 1'b1;
            div_dividend = acc_mag;
            div_divisor  = wsum_ff;
            state_in     = S_DIVY_WT;
         end
         S_DIVY_WT: begin
            if (div_done) begin
               qy_in    = accy_ff[ACC_W-1] ? -q_lo : q_lo;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = qx_ff;
               rsp_y_in      = qy_ff;
               rsp_status_in = knn_pkg::STATUS_BLEND;
               rsp_slot_in   = slot_ff;
               rsp_last_in   = slot_ff == last_slot_ff;
               if (slot_ff == last_slot_ff) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_ff + SW'(1);
                  accx_in  = '0;
                  accy_in  = '0;
                  state_in = S_SLOT_ADDR;
               end
            end
         end
         S_HIT_ADDR: begin
            state_in = S_HIT_DATA;
         end
         S_HIT_DATA: begin
            qx_in    = slot_rdata[31:16];
            qy_in    = slot_rdata[15:0];
            state_in = S_HIT_EMIT;
         end
         S_HIT_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = qx_ff;
               rsp_y_in      = qy_ff;
               rsp_status_in = knn_pkg::STATUS_HIT;
               rsp_slot_in   = slot_ff;
               rsp_last_in   = slot_ff == last_slot_ff;
               if (slot_ff == last_slot_ff) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in  = slot_ff + SW'(1);
                  state_in = S_HIT_ADDR;
               end
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_status_in = knn_pkg::STATUS_EMPTY;
               rsp_slot_in   = slot_ff;
               rsp_last_in   = slot_ff == last_slot_ff;
               if (slot_ff == last_slot_ff) begin
                  state_in = S_IDLE;
               end else begin
                  slot_in = slot_ff + SW'(1);
               end
            end
         end
         S_BAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_status_in = knn_pkg::STATUS_BAD;
               rsp_slot_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= knn_pkg::K_RESET;
         n_ff         <= '0;
         rd_v_ff      <= 1'b0;
         sq_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rd_v_ff      <= rd_v_in;
         sq_v_ff      <= sq_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fx_ff         <= fx_in;
      fy_ff         <= fy_in;
      slot_ff       <= slot_in;
      last_slot_ff  <= last_slot_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      sq_idx_ff     <= sq_idx_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      nb_ff         <= nb_in;
      for (int j = 0; j < MAX_K; j++) begin
         w_ff[j] <= w_in[j];
      end
      wsum_ff       <= wsum_in;
      prodx_ff      <= prodx_in;
      prody_ff      <= prody_in;
      accx_ff       <= accx_in;
      accy_ff       <= accy_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_number = 4'(rsp_slot_ff);
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // divider is never left running when a new request can be taken
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("divider busy while idle");

   // neighbour list never grows beyond k during a query
   a_used_le_k: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (nr_used <= k_eff))
      else $error("neighbour list overfilled");

   // invalid-slot response is a single closing response with no slot
   a_bad_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == knn_pkg::STATUS_BAD) |->
         (rsp_slot_number == 4'd0 && rsp_last))
      else $error("malformed invalid-slot response");
`endif

endmodule

>>> bench/knn_interp_checker.sv
`timescale 1ns / 1ps
module knn_interp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_sample_slot,
   input  logic [3:0]         req_player,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_pos_x,
   input  logic signed [15:0] rsp_pos_y,
   input  logic [1:0]         rsp_status,
   input  logic [3:0]         rsp_slot_number,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 results_pending,
   output int                 results_seen
);

   localparam int NSAMP = 64;
   localparam int NK    = 8;
   localparam int NSLOT = 11;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [1:0]         status;
      logic [3:0]         slot_number;
      logic               last;
   } interp_result_type;

   // mirror of the sample stores and registers
   logic signed [15:0] key_x [NSAMP];
   logic signed [15:0] key_y [NSAMP];
   logic signed [15:0] pos_x_mem [NSAMP*NSLOT];
   logic signed [15:0] pos_y_mem [NSAMP*NSLOT];
   logic [3:0]         k_reg;
   logic [6:0]         n_reg;

   interp_result_type expected_results [$];

   assign results_pending = expected_results.size();

   // appends one expected result to the tail of the queue
   function automatic void queue_result(logic signed [15:0] px,
         logic signed [15:0] py, logic [1:0] st, logic [3:0] sl, logic lst);
      interp_result_type r;
      r.pos_x = px;
      r.pos_y = py;
      r.status = st;
      r.slot_number = sl;
      r.last = lst;
      expected_results = {expected_results, r};
   endfunction

   // works out the results of one query transaction
   task automatic predict_query(input logic [3:0] player,
                                input logic signed [15:0] fx,
                                input logic signed [15:0] fy);
      int                    n, k, used, p, first_slot, last_slot;
      int                    near_idx [NK];
      longint unsigned       near_d2 [NK];
      longint unsigned       wgt [NK];
      longint unsigned       d;
      longint                dx, dy, wsum, ax, ay;
      int                    si;
      if (player > NSLOT) begin
         queue_result(16'sd0, 16'sd0, knn_pkg::STATUS_BAD, 4'd0, 1'b1);
         return;
      end
      first_slot = (player == 0) ? 1 : player;
      last_slot  = (player == 0) ? NSLOT : player;
      n = (n_reg > NSAMP) ? NSAMP : n_reg;
      k = (k_reg == 0) ? 1 : ((k_reg > NK) ? NK : k_reg);
      if (n == 0) begin
         for (int s = first_slot; s <= last_slot; s++)
            queue_result(16'sd0, 16'sd0, knn_pkg::STATUS_EMPTY, 4'(s),
                         s == last_slot);
         return;
      end
      // sorted insertion; strict compare keeps ties at the lower index
      used = 0;
      for (int i = 0; i < n; i++) begin
         dx = longint'(key_x[i]) - longint'(fx);
         dy = longint'(key_y[i]) - longint'(fy);
         d = longint'(dx * dx) + longint'(dy * dy);
         if (used < k) begin
            p = used;
            used++;
         end else if (d < near_d2[used-1]) begin
            p = used - 1;
         end else begin
            continue;
         end
         while (p > 0 && near_d2[p-1] > d) begin
            near_idx[p] = near_idx[p-1];
            near_d2[p] = near_d2[p-1];
            p--;
         end
         near_idx[p] = i;
         near_d2[p] = d;
      end
      // exact key hit
      if (near_d2[0] == 0) begin
         for (int s = first_slot; s <= last_slot; s++) begin
            si = near_idx[0] * NSLOT + s - 1;
            queue_result(pos_x_mem[si], pos_y_mem[si], knn_pkg::STATUS_HIT,
                         4'(s), s == last_slot);
         end
         return;
      end
      wsum = 0;
      for (int i = 0; i < used; i++) begin
         wgt[i] = (64'd1 << 32) / near_d2[i];
         if (wgt[i] == 0)
            wgt[i] = 1;
         wsum += longint'(wgt[i]);
      end
      for (int s = first_slot; s <= last_slot; s++) begin
         ax = 0;
         ay = 0;
         for (int i = 0; i < used; i++) begin
            si = near_idx[i] * NSLOT + s - 1;
            ax += longint'(pos_x_mem[si]) * longint'(wgt[i]);
            ay += longint'(pos_y_mem[si]) * longint'(wgt[i]);
         end
         queue_result(16'(ax / wsum), 16'(ay / wsum), knn_pkg::STATUS_BLEND,
                      4'(s), s == last_slot);
      end
   endtask

   always @(posedge clock) begin
      interp_result_type exp_r;
      if (reset) begin
         k_reg <= knn_pkg::K_RESET;
         n_reg <= 7'd0;
         expected_results.delete();
         fail_count <= 0;
         results_seen <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == knn_pkg::CSR_NEIGHBOR_COUNT)
               k_reg <= csr_wdata[3:0];
            else
               n_reg <= csr_wdata;
         end
         // request side
         if (req_valid && req_ready) begin
            case (req_func)
               knn_pkg::FUNC_LOAD_KEY: begin
                  key_x[req_sample_slot] = req_coord_x;
                  key_y[req_sample_slot] = req_coord_y;
               end
               knn_pkg::FUNC_LOAD_SLOT: begin
                  if (req_player >= 1 && req_player <= NSLOT) begin
                     pos_x_mem[req_sample_slot*NSLOT + req_player - 1] = req_coord_x;
                     pos_y_mem[req_sample_slot*NSLOT + req_player - 1] = req_coord_y;
                  end
               end
               knn_pkg::FUNC_QUERY: predict_query(req_player, req_coord_x, req_coord_y);
               default: ;
            endcase
         end
         // response side
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result pos=(%0d,%0d) status=%0d slot=%0d last=%0d",
                        $time, rsp_pos_x, rsp_pos_y, rsp_status, rsp_slot_number,
                        rsp_last);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.pos_x !== rsp_pos_x || exp_r.pos_y !== rsp_pos_y ||
                   exp_r.status !== rsp_status ||
                   exp_r.slot_number !== rsp_slot_number || exp_r.last !== rsp_last) begin
                  $display("%0t: mismatch expected pos=(%0d,%0d) status=%0d slot=%0d last=%0d",
                           $time, exp_r.pos_x, exp_r.pos_y, exp_r.status,
                           exp_r.slot_number, exp_r.last);
                  $display("%0t:          actual   pos=(%0d,%0d) status=%0d slot=%0d last=%0d",
                           $time, rsp_pos_x, rsp_pos_y, rsp_status, rsp_slot_number,
                           rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> bench/knn_inverse_distance_interpolator_tb.sv
`timescale 1ns / 1ps
module knn_inverse_distance_interpolator_tb;

   localparam int STALL_LIMIT = 20000;
   localparam int NEAR = 8;
   localparam int PHASE_ITEMS = 7;
   // function code with no meaning to the block
   localparam logic [1:0] FUNC_NONE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic [6:0]         csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = '0;
   logic [5:0]         req_sample_slot = '0;
   logic [3:0]         req_player = '0;
   logic signed [15:0] req_coord_x = '0;
   logic signed [15:0] req_coord_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_slot_number;
   logic               rsp_last;

   int fail_count, results_pending, results_seen;
   int idle_cycles = 0;
   int burst_left = 0;
   int items_sent = 0;
   int queries_sent = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_cnt = 0;
   int stretch_len = 0;
   int ready_mode = 0;

   // near sample keys, kept so queries can land exactly on one
   logic signed [15:0] near_kx [NEAR];
   logic signed [15:0] near_ky [NEAR];

   always #1 clock = ~clock;

   knn_inverse_distance_interpolator dut (.*);

   knn_interp_checker checker_i (.*);

   // receiver: stretches of differing readiness, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_cnt <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_len == 0) begin
            stretch_len <= $urandom_range(10, 60);
            ready_mode <= $urandom_range(0, 2);
         end else begin
            stretch_len <= stretch_len - 1;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
         $display("knn_inverse_distance_interpolator_tb: errors");
         $finish;
      end
   end

   // one request transaction, with burst gaps in front of it
   task automatic send(input logic [1:0] func, input logic [5:0] sidx,
                       input logic [3:0] player, input logic signed [15:0] cx,
                       input logic signed [15:0] cy);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= func;
      req_sample_slot <= sidx;
      req_player <= player;
      req_coord_x <= cx;
      req_coord_y <= cy;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (func == knn_pkg::FUNC_QUERY)
         queries_sent++;
   endtask

   // lower valid and wait for every expected result, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (results_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_regs(input logic [3:0] k, input logic [6:0] n);
      drain();
      csr_we <= 1'b1;
      csr_index <= knn_pkg::CSR_NEIGHBOR_COUNT;
      csr_wdata <= {3'd0, k};
      @(negedge clock);
      csr_index <= knn_pkg::CSR_SAMPLES_IN_USE;
      csr_wdata <= n;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_near_key(input int i, input bit wide);
      logic signed [15:0] x, y;
      x = wide ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      y = wide ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      near_kx[i] = x;
      near_ky[i] = y;
      send(knn_pkg::FUNC_LOAD_KEY, 6'(i), 4'd0, x, y);
   endtask

   // one random transaction; far samples only take part when n is above NEAR
   task automatic random_item(input int n);
      int                 r, j;
      bit                 wide;
      logic [3:0]         pl;
      logic signed [15:0] fx, fy;
      wide = (n <= NEAR);
      r = $urandom_range(0, 99);
      if (r < 55) begin
         pl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
         if (n > 0 && $urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, ((n < NEAR) ? n : NEAR) - 1);
            fx = near_kx[j];
            fy = near_ky[j];
         end else if (wide) begin
            fx = 16'($urandom);
            fy = 16'($urandom);
         end else begin
            fx = 16'($urandom_range(0, 4000) - 2000);
            fy = 16'($urandom_range(0, 4000) - 2000);
         end
         send(knn_pkg::FUNC_QUERY, 6'($urandom), pl, fx, fy);
      end else if (r < 80) begin
         pl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 11));
         send(knn_pkg::FUNC_LOAD_SLOT, 6'($urandom_range(0, NEAR - 1)), pl,
              16'($urandom), 16'($urandom));
      end else if (r < 95) begin
         load_near_key($urandom_range(0, NEAR - 1), wide);
      end else begin
         send(FUNC_NONE, 6'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      logic [3:0] k_list [9];
      logic [6:0] n_list [9];
      k_list = '{4'd1, 4'd3, 4'd8, 4'd0, 4'd15, 4'd8, 4'd5, 4'd2, 4'd4};
      n_list = '{7'd1, 7'd4, 7'd8, 7'd6, 7'd2, 7'd64, 7'd127, 7'd20, 7'd8};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty set at reset values, invalid slot, unused function, ignored loads
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd0, 16'sh7fff, -16'sh8000);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd11, 16'sd0, 16'sd0);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd1, -16'sh8000, 16'sh7fff);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd12, 16'sd0, 16'sd0);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd15, 16'sd1, 16'sd1);
      send(FUNC_NONE, 6'd63, 4'd15, 16'shffff, 16'shffff);
      send(knn_pkg::FUNC_LOAD_SLOT, 6'd0, 4'd0, 16'sd5, 16'sd5);
      send(knn_pkg::FUNC_LOAD_SLOT, 6'd1, 4'd13, 16'sd5, 16'sd5);

      // near samples: key and all slot positions, extremes included
      for (int i = 0; i < NEAR; i++) begin
         load_near_key(i, 1'b0);
         for (int s = 1; s <= 11; s++)
            send(knn_pkg::FUNC_LOAD_SLOT, 6'(i), 4'(s),
                 (i == 0) ? 16'sh7fff : (i == 1) ? -16'sh8000 : 16'($urandom),
                 (i == 0) ? -16'sh8000 : (i == 1) ? 16'sh7fff : 16'($urandom));
      end
      // far keys for the rest; never chosen while the focus stays near
      for (int i = NEAR; i < 64; i++)
         send(knn_pkg::FUNC_LOAD_KEY, 6'(i), 4'd0,
              16'(($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000)
                  - 16'($urandom_range(0, 2700)) * ((i % 2) ? 1 : -1)),
              16'(($urandom_range(0, 1) ? 16'sh7fff : -16'sh8000)
                  - 16'($urandom_range(0, 2700)) * ((i % 3) ? 1 : -1)));

      // directed queries: exact hit, far focus, single slot and all slots
      write_regs(4'd8, 7'd8);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd0, near_kx[0], near_ky[0]);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd5, near_kx[3], near_ky[3]);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd0, 16'sh7fff, 16'sh7fff);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd11, -16'sh8000, -16'sh8000);
      send(knn_pkg::FUNC_QUERY, 6'd0, 4'd1, 16'sd1, -16'sd1);

      // random phases through the register settings
      for (int ph = 0; ph < 9; ph++) begin
         write_regs(k_list[ph], n_list[ph]);
         if (n_list[ph] > NEAR)
            for (int i = 0; i < NEAR; i++)
               load_near_key(i, 1'b0);
         for (int it = 0; it < PHASE_ITEMS; it++) begin
            // long receiver hold-off while an all-slot query and more requests come
            if (ph == 2 && it == 2) begin
               hold_token++;
               send(knn_pkg::FUNC_QUERY, 6'd0, 4'd0, near_kx[1], near_ky[1]);
            end
            // sender pause until all results are in
            if (ph == 4 && it == 3)
               drain();
            random_item((n_list[ph] > 64) ? 64 : n_list[ph]);
         end
      end

      drain();
      repeat (100) @(negedge clock);
      $display("Covered %0d request transactions (%0d queries), %0d results checked,",
               items_sent, queries_sent, results_seen);
      $display("k from 0 to 15 and samples in use from 0 to 127.");
      if (fail_count == 0 && results_pending == 0)
         $display("knn_inverse_distance_interpolator_tb: clean");
      else
         $display("knn_inverse_distance_interpolator_tb: errors");
      $finish;
   end

endmodule
